@@ sv/fpba_pkg.sv @@
`timescale 1ns / 1ps

package fpba_pkg;

  // Default table geometry
  localparam int NumBlocksDef = 16;
  localparam int SizeBitsDef  = 16;

  // Field and register widths
  localparam int IndexW    = 4;
  localparam int SizeW     = 16;
  localparam int StatusW   = 2;
  localparam int ModeW     = 2;
  localparam int CountW    = 5;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FIT_MODE    = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_COUNT = 1'd1;

  // Fit policies
  localparam logic [ModeW-1:0] MODE_FIRST = 2'd0;
  localparam logic [ModeW-1:0] MODE_BEST  = 2'd1;
  localparam logic [ModeW-1:0] MODE_NEXT  = 2'd2;
  localparam logic [ModeW-1:0] MODE_WORST = 2'd3;

  // Result status codes
  localparam logic [StatusW-1:0] STAT_LOADED = 2'd0;
  localparam logic [StatusW-1:0] STAT_ALLOC  = 2'd1;
  localparam logic [StatusW-1:0] STAT_NOFIT  = 2'd2;

  // Request actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  // Register reset values
  localparam logic [ModeW-1:0]  FIT_MODE_RST    = MODE_FIRST;
  localparam logic [CountW-1:0] BLOCK_COUNT_RST = 5'd16;

endpackage

@@ sv/fit_policy_block_allocator.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake                  Payload
// -------  ---------  -------------------------  ---------------------------------------
// in       input      in_valid_i / in_stall_o    action_i, block_index_i, size_value_i
// out      output     out_valid_o / out_stall_i  status_o, chosen_index_o
// cfg      input      cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// A load takes one cycle: it writes the table and its result is registered at once.
// An allocation result is registered after these steps, once the request is taken:
// read issue, a compare for each of the n scanned entries (n = 16 at 16 blocks)
// through the single memory read port and one shared subtract/compare unit, then
// write-back. The next request is taken only after the result appears, once the
// sequencer is back in idle and the output register is free.
// rst_ni clears the table through per-entry valid bits, so no clearing pass runs.
// A result waits in the output register while out_stall_i is high; write-back and
// loads hold until that register is free.

module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = NumBlocksDef,
  parameter int SIZE_BITS  = SizeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [IndexW-1:0]   block_index_i,
  input  logic [SizeW-1:0]    size_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [StatusW-1:0]  status_o,
  output logic [IndexW-1:0]   chosen_index_o
);

  localparam int IdxW = $clog2(NUM_BLOCKS);
  localparam int CntW = $clog2(NUM_BLOCKS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [ModeW-1:0]      fit_mode_q;
  logic [CountW-1:0]     block_count_q;
  logic [IdxW-1:0]       rover_q;

  logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld_q;

  logic [SIZE_BITS-1:0]  req_q;
  logic [CntW-1:0]       n_q;
  logic [CntW-1:0]       iss_cnt_q;
  logic [IdxW-1:0]       ptr_q;
  logic                  rd_vld_q;
  logic [IdxW-1:0]       rd_idx_q;
  logic [SIZE_BITS-1:0]  rdata_q;
  logic                  rvld_q;
  logic                  found_q;
  logic [IdxW-1:0]       pick_q;
  logic [SIZE_BITS-1:0]  best_left_q;

  logic                  out_valid_q;
  logic [StatusW-1:0]    out_status_q;
  logic [IndexW-1:0]     out_index_q;

  logic                  in_acc;
  logic                  out_free;
  logic                  load_we;
  logic                  load_in_range;
  logic                  wb_go;
  logic [CntW-1:0]       n_now;
  logic [IdxW-1:0]       start_idx;
  logic [SIZE_BITS-1:0]  eff;
  logic [SIZE_BITS:0]    diff;
  logic                  fits;
  logic                  take;
  logic                  iss_busy;
  logic [IdxW-1:0]       ptr_nxt;
  logic [IdxW-1:0]       rover_nxt;

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign load_in_range = (32'(block_index_i) < NUM_BLOCKS);
  assign load_we       = in_acc && (action_i == ACT_LOAD) && load_in_range;
  assign wb_go         = (state_q == ST_WB) && out_free;

  // Clamp the scanned count to the table depth
  assign n_now = (32'(block_count_q) > NUM_BLOCKS) ? CntW'(NUM_BLOCKS)
                                                   : CntW'(block_count_q);

  // Pick the scan start: the rover for next fit, entry zero otherwise
  always_comb begin
    start_idx = '0;
    if (fit_mode_q == MODE_NEXT && CntW'(rover_q) < n_now) begin
      start_idx = rover_q;
    end
  end

  // Shared unit: leftover size and fit test on the entry just read
  assign eff  = rvld_q ? rdata_q : '0;
  assign diff = {1'b0, eff} - {1'b0, req_q};
  assign fits = !diff[SIZE_BITS];

  always_comb begin
    take = 1'b0;
    if (rd_vld_q && fits) begin
      case (fit_mode_q)
        MODE_BEST:  take = !found_q || (diff[SIZE_BITS-1:0] < best_left_q);
        MODE_WORST: take = !found_q || (diff[SIZE_BITS-1:0] > best_left_q);
        default:    take = !found_q;
      endcase
    end
  end

  assign iss_busy  = (iss_cnt_q != n_q);
  assign ptr_nxt   = (CntW'(ptr_q) + CntW'(1) == n_q) ? '0 : ptr_q + IdxW'(1);
  assign rover_nxt = (CntW'(pick_q) + CntW'(1) >= n_q) ? '0 : pick_q + IdxW'(1);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && action_i == ACT_ALLOC) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!iss_busy) state_d = ST_WB;
      end
      ST_WB: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= FIT_MODE_RST;
      block_count_q <= BLOCK_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FIT_MODE:    fit_mode_q    <= cfg_wdata_i[ModeW-1:0];
        CFG_BLOCK_COUNT: block_count_q <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      mem[IdxW'(block_index_i)] <= SIZE_BITS'(size_value_i);
    end else if (wb_go && found_q) begin
      mem[pick_q] <= best_left_q;
    end
    rdata_q <= mem[ptr_q];
  end

  // Entry valid bits: an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (load_we) vld_q[IdxW'(block_index_i)] <= 1'b1;
      rvld_q <= vld_q[ptr_q];
    end
  end

  // Scan control and rover
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rover_q   <= '0;
      iss_cnt_q <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      if (in_acc && action_i == ACT_ALLOC) begin
        iss_cnt_q <= '0;
        rd_vld_q  <= 1'b0;
        found_q   <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        rd_vld_q <= iss_busy;
        if (iss_busy) iss_cnt_q <= iss_cnt_q + CntW'(1);
        if (take) found_q <= 1'b1;
      end
      if (wb_go && found_q && fit_mode_q == MODE_NEXT) begin
        rover_q <= rover_nxt;
      end
    end
  end

  // Request latch, read pointer and best candidate
  always_ff @(posedge clk_i) begin
    if (in_acc && action_i == ACT_ALLOC) begin
      req_q <= SIZE_BITS'(size_value_i);
      n_q   <= n_now;
      ptr_q <= start_idx;
    end else if (state_q == ST_SCAN) begin
      if (iss_busy) begin
        ptr_q    <= ptr_nxt;
        rd_idx_q <= ptr_q;
      end
      if (take) begin
        pick_q      <= rd_idx_q;
        best_left_q <= diff[SIZE_BITS-1:0];
      end
    end
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((in_acc && action_i == ACT_LOAD) || wb_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && action_i == ACT_LOAD) begin
      out_status_q <= STAT_LOADED;
      out_index_q  <= block_index_i;
    end else if (wb_go) begin
      out_status_q <= found_q ? STAT_ALLOC : STAT_NOFIT;
      out_index_q  <= found_q ? IndexW'(pick_q) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign chosen_index_o = out_index_q;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import fpba_pkg::*;

  localparam int CycleLimit  = 1_000_000;
  localparam int SettleDelay = NumBlocksDef + 8;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IndexW-1:0]  chosen;
  } grant_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CFG_FIT_MODE;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                action = ACT_LOAD;
  logic [IndexW-1:0]   block_index = '0;
  logic [SizeW-1:0]    size_value = '0;
  logic                out_stall = 1'b0;
  wire                 in_stall;
  wire                 out_valid;
  wire [StatusW-1:0]   status;
  wire [IndexW-1:0]    chosen_index;

  // Allocator mirror: free table, rover and register copies
  logic [SizeW-1:0]  free_tbl [NumBlocksDef];
  int                rover_pos = 0;
  logic [ModeW-1:0]  cur_mode = FIT_MODE_RST;
  logic [CountW-1:0] cur_count = BLOCK_COUNT_RST;

  grant_t due_grants[$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     stall_enable = 1'b1;
  bit     gaps_enable = 1'b1;
  int     stall_left = 0;
  int     run_left = 0;

  fit_policy_block_allocator uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .block_index_i  (block_index),
    .size_value_i   (size_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .chosen_index_o (chosen_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < NumBlocksDef; i++) free_tbl[i] = '0;
  end

  // Apply one request to the mirror and return the grant it should produce
  function automatic grant_t fit_grant(logic act, logic [IndexW-1:0] idx,
                                       logic [SizeW-1:0] sz);
    grant_t res;
    int     n, start, j, pick, left, best_left, i, k;
    bit     found;
    res.status = STAT_NOFIT;
    res.chosen = '0;
    found = 1'b0;
    pick = 0;
    best_left = 0;
    if (act == ACT_LOAD) begin
      free_tbl[idx] = sz;
      res.status = STAT_LOADED;
      res.chosen = idx;
      return res;
    end
    n = (int'(cur_count) > NumBlocksDef) ? NumBlocksDef : int'(cur_count);
    if (cur_mode == MODE_NEXT) begin
      // circular scan from the rover; an out-of-range rover restarts at 0
      start = (rover_pos < n) ? rover_pos : 0;
      for (k = 0; k < n && !found; k++) begin
        j = (start + k) % n;
        if (free_tbl[j] >= sz) begin
          found = 1'b1;
          pick = j;
        end
      end
    end else begin
      // first hit wins for first fit; ties keep the lower index
      for (i = 0; i < n; i++) begin
        if (free_tbl[i] >= sz) begin
          left = int'(free_tbl[i]) - int'(sz);
          if (!found || (cur_mode == MODE_BEST && left < best_left) ||
              (cur_mode == MODE_WORST && left > best_left)) begin
            found = 1'b1;
            pick = i;
            best_left = left;
          end
        end
      end
    end
    if (found) begin
      free_tbl[pick] = free_tbl[pick] - sz;
      if (cur_mode == MODE_NEXT) rover_pos = (pick + 1 >= n) ? 0 : pick + 1;
      res.status = STAT_ALLOC;
      res.chosen = pick[IndexW-1:0];
    end
    return res;
  endfunction

  // Track register writes, check grants, predict accepted requests
  always @(posedge clk) begin
    grant_t want;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == CFG_FIT_MODE) cur_mode = cfg_wdata[ModeW-1:0];
        else if (cfg_index == CFG_BLOCK_COUNT) cur_count = cfg_wdata[CountW-1:0];
      end
      if (out_valid && !out_stall) begin
        if (due_grants.size() == 0) begin
          $error("grant with no request pending: status %0d index %0d",
                 status, chosen_index);
          mismatches++;
        end else begin
          want = due_grants.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
          end
          if (chosen_index !== want.chosen) begin
            $error("chosen_index: expected %0d, got %0d", want.chosen, chosen_index);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        due_grants.push_back(fit_grant(action, block_index, size_value));
    end
  end

  // Receiver backpressure: short bursts mostly, a few long ones, quiet runs between
  always @(negedge clk) begin
    if (!stall_enable) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (run_left != 0) begin
      out_stall <= 1'b0;
      run_left--;
    end else begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) - 1
                                                : $urandom_range(1, 3) - 1;
      run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(0, 4);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAIL fit_policy_block_allocator");
      $finish;
    end
  end

  // Drive one request, hold it until taken, then maybe idle a while
  task automatic send_request(logic act, logic [IndexW-1:0] idx,
                              logic [SizeW-1:0] sz);
    int r, gap;
    gap = 0;
    @(negedge clk);
    in_valid    <= 1'b1;
    action      <= act;
    block_index <= idx;
    size_value  <= sz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gaps_enable) begin
      r = $urandom_range(0, 19);
      gap = (r < 10) ? 0 : (r < 18) ? $urandom_range(1, 3) : $urandom_range(5, 30);
    end
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every grant is back and the block is quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_grants.size() != 0) @(posedge clk);
    repeat (SettleDelay) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_policy(logic [ModeW-1:0] mode, logic [CountW-1:0] count);
    settle();
    write_reg(CFG_FIT_MODE, CfgDataW'(mode));
    write_reg(CFG_BLOCK_COUNT, CfgDataW'(count));
  endtask

  // Cleared table, reset settings: zero fits, nonzero misses, then a load fits all-ones
  task automatic test_reset_defaults();
    send_request(ACT_ALLOC, 4'hF, 16'h0000);
    send_request(ACT_ALLOC, 4'h0, 16'h0001);
    send_request(ACT_LOAD, 4'hF, 16'hFFFF);
    send_request(ACT_ALLOC, 4'h0, 16'hFFFF);
  endtask

  // Three loaded entries; each policy in turn allocates twice from what is left
  task automatic test_fit_policies();
    logic [ModeW-1:0] order [4];
    order = '{MODE_FIRST, MODE_BEST, MODE_NEXT, MODE_WORST};
    send_request(ACT_LOAD, 4'h0, 16'd100);
    send_request(ACT_LOAD, 4'h5, 16'd300);
    send_request(ACT_LOAD, 4'h9, 16'd150);
    foreach (order[m]) begin
      set_policy(order[m], 5'd16);
      send_request(ACT_ALLOC, 4'h3, 16'd50);
      send_request(ACT_ALLOC, 4'hC, 16'd50);
    end
  endtask

  // Oversized, undersized and zero counts; rover beyond the count; load past count
  task automatic test_count_limits();
    set_policy(MODE_NEXT, 5'd31);
    send_request(ACT_ALLOC, 4'h0, 16'd10);
    set_policy(MODE_NEXT, 5'd2);
    send_request(ACT_ALLOC, 4'h0, 16'd10);
    set_policy(MODE_FIRST, 5'd0);
    send_request(ACT_ALLOC, 4'h0, 16'd0);
    set_policy(MODE_FIRST, 5'd4);
    send_request(ACT_LOAD, 4'hC, 16'hFFFF);
    send_request(ACT_ALLOC, 4'h0, 16'hF000);
    set_policy(MODE_FIRST, 5'd16);
    send_request(ACT_ALLOC, 4'h0, 16'hF000);
  endtask

  // Random load/allocate mix, loads mostly aimed inside the scanned range
  task automatic send_random_item(logic [CountW-1:0] count);
    int               r;
    logic [IndexW-1:0] idx;
    logic [SizeW-1:0]  sz;
    idx = IndexW'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 35) begin
      if (count != 0 && $urandom_range(0, 9) < 7)
        idx = IndexW'($urandom_range(0, (count > 16 ? 16 : count) - 1));
      sz = (r < 50) ? SizeW'($urandom_range(0, 1023)) :
           (r < 75) ? SizeW'($urandom) :
           (r < 85) ? 16'hFFFF : 16'h0000;
      send_request(ACT_LOAD, idx, sz);
    end else begin
      sz = (r < 50) ? SizeW'($urandom_range(0, 127)) :
           (r < 70) ? SizeW'($urandom_range(0, 1023)) :
           (r < 80) ? SizeW'($urandom) :
           (r < 90) ? 16'h0000 : 16'hFFFF;
      send_request(ACT_ALLOC, idx, sz);
    end
  endtask

  task automatic test_random_traffic();
    logic [ModeW-1:0]  order [4];
    logic [CountW-1:0] count;
    int                r;
    order = '{MODE_FIRST, MODE_BEST, MODE_NEXT, MODE_WORST};
    for (int phase = 0; phase < 12; phase++) begin
      r = $urandom_range(0, 9);
      case (phase)
        0: count = 5'd16;
        1: count = 5'd1;
        2: count = 5'd31;
        3: count = 5'd2;
        default: count = (r < 6) ? CountW'($urandom_range(1, 16)) :
                         (r < 8) ? 5'd16 :
                         (r < 9) ? CountW'($urandom_range(17, 31)) : 5'd0;
      endcase
      set_policy(order[phase % 4], count);
      stall_enable = (phase % 5) != 4;
      gaps_enable  = (phase % 3) != 2;
      repeat (155) send_random_item(count);
    end
    stall_enable = 1'b1;
    gaps_enable  = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_fit_policies();
    test_count_limits();
    test_random_traffic();

    settle();
    if (mismatches == 0 && due_grants.size() == 0) begin
      $display("PASS fit_policy_block_allocator");
    end else begin
      $display("FAIL fit_policy_block_allocator");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/fpba_pkg.sv
sv/fit_policy_block_allocator.sv
bench/tb.sv
